// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication or plain property, held off during reset.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: rtl/cfsd_pkg.sv
// Types, constants and helper functions of the CAN frame signal decoder.
package cfsd_pkg;

  localparam int unsigned IdW    = 29;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaskW  = 11;
  localparam int unsigned QtyW   = 4;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned ValW   = 15;
  localparam int unsigned MaxRes = 3;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [AddrW-1:0] ADDR_SHOWN_MASK = 3'h0;
  localparam logic [MaskW-1:0] SHOWN_MASK_RST  = 11'h7FF;

  localparam logic [IdW-1:0] ID_TEMPS    = 29'h640;
  localparam logic [IdW-1:0] ID_GEAR     = 29'h3C8;
  localparam logic [IdW-1:0] ID_FUEL_AMB = 29'h6B7;
  localparam logic [IdW-1:0] ID_RPM      = 29'h0A8;
  localparam logic [IdW-1:0] ID_SPEED    = 29'h0FD;
  localparam logic [IdW-1:0] ID_THROTTLE = 29'h121;
  localparam logic [IdW-1:0] ID_FAN      = 29'h3DD;
  localparam logic [IdW-1:0] ID_LOAD     = 29'h365;

  localparam logic [QtyW-1:0] Q_COOLANT  = 4'd0;
  localparam logic [QtyW-1:0] Q_ENG_OIL  = 4'd1;
  localparam logic [QtyW-1:0] Q_GEAR_OIL = 4'd2;
  localparam logic [QtyW-1:0] Q_FUEL     = 4'd3;
  localparam logic [QtyW-1:0] Q_RPM      = 4'd4;
  localparam logic [QtyW-1:0] Q_SPEED    = 4'd5;
  localparam logic [QtyW-1:0] Q_AMBIENT  = 4'd6;
  localparam logic [QtyW-1:0] Q_INTAKE   = 4'd7;
  localparam logic [QtyW-1:0] Q_THROTTLE = 4'd8;
  localparam logic [QtyW-1:0] Q_FAN      = 4'd9;
  localparam logic [QtyW-1:0] Q_LOAD     = 4'd10;
  localparam logic [QtyW-1:0] Q_LAST     = Q_LOAD;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    logic [QtyW-1:0]  quantity;
    logic [ValW-1:0]  reading;
  } entry_t;

  function automatic logic [SlotW-1:0] slot_of(input logic [MaskW-1:0] mask,
                                               input logic [QtyW-1:0]  q);
    logic [SlotW-1:0] n;
    n = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (QtyW'(i) < q) begin
        n = n + SlotW'(mask[i]);
      end
    end
    return n;
  endfunction

  function automatic entry_t make_entry(input logic [MaskW-1:0] mask,
                                        input logic [QtyW-1:0]  q,
                                        input logic [ValW-1:0]  val);
    entry_t e;
    e.en       = mask[q];
    e.slot     = slot_of(mask, q);
    e.quantity = q;
    e.reading  = val;
    return e;
  endfunction

endpackage

// File: rtl/can_frame_signal_decoder.sv
// CAN frame signal decoder: frame decode, scaling and result serialization.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+-------------------------------------
//   frame in | in_valid_i / in_stall_o | frame_id_i, byte_1_i .. byte_7_i
//   result   | out_valid_o/out_stall_i | slot_o, quantity_o, reading_o, last_o
//   config   | APB psel / penable      | paddr, pwdata, prdata
//
// A frame is held in the input register and is decoded into a
// three-entry result buffer, from which one word per cycle moves to the
// output register while the result side does not stall. The buffer takes
// the next frame once its last pending result leaves. The first result
// word passes the input register, the result buffer and the output register.
// Reset sets shown_mask to all ones and empties every stage.
// A stall on the result side backs up through the buffer to in_stall_o.
module can_frame_signal_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cfsd_pkg::IdW-1:0]          frame_id_i,
  input  logic [cfsd_pkg::ByteW-1:0]        byte_1_i,
  input  logic [cfsd_pkg::ByteW-1:0]        byte_2_i,
  input  logic [cfsd_pkg::ByteW-1:0]        byte_3_i,
  input  logic [cfsd_pkg::ByteW-1:0]        byte_4_i,
  input  logic [cfsd_pkg::ByteW-1:0]        byte_5_i,
  input  logic [cfsd_pkg::ByteW-1:0]        byte_6_i,
  input  logic [cfsd_pkg::ByteW-1:0]        byte_7_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cfsd_pkg::SlotW-1:0]        slot_o,
  output logic [cfsd_pkg::QtyW-1:0]         quantity_o,
  output logic signed [cfsd_pkg::ValW-1:0]  reading_o,
  output logic                              last_o,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cfsd_pkg::AddrW-1:0]        paddr,
  input  logic [cfsd_pkg::DataW-1:0]        pwdata,
  output logic [cfsd_pkg::DataW-1:0]        prdata,
  output logic                              pready
);

  logic [cfsd_pkg::MaskW-1:0] shown_mask_q;
  logic                       cfg_wr;

  logic                       in_valid_q, in_valid_d;
  logic                       in_take;
  logic [cfsd_pkg::IdW-1:0]   frame_id_q;
  logic [cfsd_pkg::ByteW-1:0] b1_q, b2_q, b3_q, b4_q, b5_q, b6_q, b7_q;

  logic [9:0]                 cool_t, intake_t;
  logic [15:0]                spd_x;
  logic [32:0]                spd_prod;
  logic [17:0]                thr_prod;
  logic [15:0]                load_num;
  logic [24:0]                load_prod;
  logic [cfsd_pkg::ValW-1:0]  v_coolant, v_eng_oil, v_gear_oil, v_fuel, v_rpm;
  logic [cfsd_pkg::ValW-1:0]  v_speed, v_ambient, v_intake, v_throttle, v_fan, v_load;

  cfsd_pkg::entry_t           dec [cfsd_pkg::MaxRes];
  logic [cfsd_pkg::MaxRes-1:0] dec_en;

  cfsd_pkg::entry_t           batch_q [cfsd_pkg::MaxRes];
  logic [cfsd_pkg::MaxRes-1:0] pend_q, pend_d;
  logic [cfsd_pkg::MaxRes-1:0] sel, pend_rest, pend_after;
  logic                       pop, batch_load, out_free;
  cfsd_pkg::entry_t           pick;

  logic                       out_valid_q, out_valid_d;
  logic [cfsd_pkg::SlotW-1:0] slot_q;
  logic [cfsd_pkg::QtyW-1:0]  quantity_q;
  logic [cfsd_pkg::ValW-1:0]  reading_q;
  logic                       last_q;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == cfsd_pkg::ADDR_SHOWN_MASK);

  always_comb begin
    prdata = '0;
    if (paddr == cfsd_pkg::ADDR_SHOWN_MASK) begin
      prdata = cfsd_pkg::DataW'(shown_mask_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_mask_q <= cfsd_pkg::SHOWN_MASK_RST;
    end else if (cfg_wr) begin
      shown_mask_q <= pwdata[cfsd_pkg::MaskW-1:0];
    end
  end

  // Scaling of every quantity from the registered frame bytes.
  always_comb begin
    cool_t     = {2'b00, b3_q} + {1'b0, b3_q, 1'b0};
    intake_t   = {2'b00, b1_q} + {1'b0, b1_q, 1'b0};
    spd_x      = {b4_q, b5_q};
    spd_prod   = 33'(spd_x) * 33'(17'd83887);
    thr_prod   = 18'(b1_q) * 18'(9'd410);
    load_num   = {1'b0, b4_q, 7'b0} + 16'(b4_q) + 16'd1;
    load_prod  = 25'(load_num[15:3]) * 25'(12'd3277);

    v_coolant  = 15'(cool_t[9:2]) - 15'd48;
    v_eng_oil  = 15'(b2_q) - 15'd60;
    v_intake   = 15'(intake_t[9:2]) - 15'd48;
    v_gear_oil = 15'(b7_q) - 15'd58;
    v_fuel     = 15'(b5_q[6:0]);
    v_ambient  = 15'(b7_q[7:1]) - 15'd50;
    v_rpm      = 15'({b6_q, b7_q[7:2]});
    v_speed    = 15'(spd_prod[32:23]);
    v_throttle = 15'(thr_prod[17:10]);
    v_fan      = 15'(b5_q);
    v_load     = 15'(load_prod[23:14]);
  end

  // Frame decode into up to three ordered result entries.
  always_comb begin
    for (int k = 0; k < cfsd_pkg::MaxRes; k++) begin
      dec[k] = '0;
    end
    unique case (frame_id_q)
      cfsd_pkg::ID_TEMPS: begin
        dec[0] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_COOLANT, v_coolant);
        dec[1] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_ENG_OIL, v_eng_oil);
        dec[2] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_INTAKE, v_intake);
      end
      cfsd_pkg::ID_GEAR: begin
        dec[0] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_GEAR_OIL, v_gear_oil);
      end
      cfsd_pkg::ID_FUEL_AMB: begin
        dec[0] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_FUEL, v_fuel);
        dec[1] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_AMBIENT, v_ambient);
      end
      cfsd_pkg::ID_RPM: begin
        dec[0] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_RPM, v_rpm);
      end
      cfsd_pkg::ID_SPEED: begin
        dec[0] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_SPEED, v_speed);
      end
      cfsd_pkg::ID_THROTTLE: begin
        dec[0] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_THROTTLE, v_throttle);
      end
      cfsd_pkg::ID_FAN: begin
        dec[0] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_FAN, v_fan);
      end
      cfsd_pkg::ID_LOAD: begin
        dec[0] = cfsd_pkg::make_entry(shown_mask_q, cfsd_pkg::Q_LOAD, v_load);
      end
      default: begin
      end
    endcase
    for (int k = 0; k < cfsd_pkg::MaxRes; k++) begin
      dec_en[k] = dec[k].en;
    end
  end

  // Result buffer: pop the oldest pending entry, refill once it drains.
  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    sel        = pend_q & (~pend_q + 3'd1);
    pend_rest  = pend_q & ~sel;
    pop        = out_free && (pend_q != '0);
    pend_after = pop ? pend_rest : pend_q;
    batch_load = in_valid_q && (pend_after == '0);
    pend_d     = batch_load ? dec_en : pend_after;
    in_take    = !in_valid_q || batch_load;
    in_valid_d = in_take ? in_valid_i : in_valid_q;
    out_valid_d = out_free ? pop : out_valid_q;
    if (sel[0]) begin
      pick = batch_q[0];
    end else if (sel[1]) begin
      pick = batch_q[1];
    end else begin
      pick = batch_q[2];
    end
  end

  assign in_stall_o = !in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && in_valid_i) begin
      frame_id_q <= frame_id_i;
      b1_q       <= byte_1_i;
      b2_q       <= byte_2_i;
      b3_q       <= byte_3_i;
      b4_q       <= byte_4_i;
      b5_q       <= byte_5_i;
      b6_q       <= byte_6_i;
      b7_q       <= byte_7_i;
    end
    if (batch_load) begin
      for (int k = 0; k < cfsd_pkg::MaxRes; k++) begin
        batch_q[k] <= dec[k];
      end
    end
    if (out_free && pop) begin
      slot_q     <= pick.slot;
      quantity_q <= pick.quantity;
      reading_q  <= pick.reading;
      last_q     <= (pend_rest == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign quantity_o  = quantity_q;
  assign reading_o   = $signed(reading_q);
  assign last_o      = last_q;

endmodule

// File: rtl/cfsd_checker.sv
// Port-level checker for the CAN frame signal decoder and its bind.
`include "assert_macros.svh"

module cfsd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [cfsd_pkg::SlotW-1:0]       slot_o,
  input logic [cfsd_pkg::QtyW-1:0]        quantity_o,
  input logic signed [cfsd_pkg::ValW-1:0] reading_o,
  input logic                             last_o
);

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result word dropped while stalled")
  `ASSERT_PROP(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(reading_o) && $stable(last_o), "stalled result word changed")
  `ASSERT_NEVER(a_qty_range, clk_i, rst_ni, out_valid_o && (quantity_o > cfsd_pkg::Q_LAST), "quantity code out of range")
  `ASSERT_NEVER(a_slot_dense, clk_i, rst_ni, out_valid_o && (slot_o > quantity_o), "slot exceeds quantity code")

endmodule

bind can_frame_signal_decoder cfsd_checker u_cfsd_checker (.*);
